// ===== rtl/selective_repeat_sender_macros.svh =====
// Assertion macros for the selective repeat sender.
// Used by the datapath; no other dependencies.
`ifndef SELECTIVE_REPEAT_SENDER_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_MACROS_SVH
`ifndef SYNTHESIS
`define SRS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRS_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SRS_ASSERT(name, clk, rst, prop, msg)
`define SRS_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/srs_pkg.sv =====
// Shared types and constants for the selective repeat sender.
// No dependencies.
`timescale 1ns / 1ps
package srs_pkg;

   localparam int FRAME_LIMIT  = 128;
   localparam int WINDOW_LIMIT = 32;

   // fixed field widths
   localparam int ACK_W       = 7;
   localparam int FRAME_NUM_W = 7;
   localparam int KIND_W      = 2;
   localparam int TOTAL_W     = 8;
   localparam int WINDOW_W    = 6;
   localparam int TIMEOUT_W   = 15;
   localparam int STAMP_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // derived widths
   localparam int FRAME_W = $clog2(FRAME_LIMIT);
   localparam int COUNT_W = $clog2(FRAME_LIMIT + 1);
   localparam int SUM_W   = COUNT_W + 1;
   localparam int WIN_W   = $clog2(WINDOW_LIMIT + 1);
   localparam int EXT_W   = 16;

   // register reset values
   localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = TOTAL_W'(128);
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(4);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10);

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ACK  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW  = 2'd0,
      KIND_RETX = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLIDE,
      ST_SLIDE_CHK,
      ST_SCAN,
      ST_SCAN_CMP,
      ST_END_CHK,
      ST_SEND,
      ST_FLUSH,
      ST_FLUSH_END,
      ST_FINISHED
   } state_type;

   typedef struct packed {
      logic accept;
      logic slide_read;
      logic slide_step;
      logic scan_adv;
      logic scan_read;
      logic retx;
      logic end_mark;
      logic send_new;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slide_more;
      logic scan_done;
      logic scan_acked;
      logic timed_out;
      logic at_end;
      logic send_more;
      logic emit_ok;
   } dp_status_type;

endpackage

// ===== rtl/selective_repeat_sender.sv =====
// Selective repeat ARQ sender, top level. Uses srs_pkg, srs_ctrl, srs_datapath.
//
// Request channel (req_): one transfer per event, a time tick or an arriving
// ack carrying req_ack_number. Response channel (rsp_): retransmits in
// ascending order, then either new sends or the end marker; rsp_last flags the
// final response of one request. CSR port: plain writes, index 0 total
// frames, 1 window, 2 timeout; write it only while the block is idle.
//
// Sequence: after the request transfer, an ack walks the base over acked frames
// (ack RAM read, then test); a tick scans every outstanding frame (ack and stamp
// RAM read, then age compare, resending timed-out frames). Then come the end
// check, the new sends or the end marker, and the release of the last response.
// Each response is held back until the next so its last flag is known; the final one
// waits in the output register while the next request is taken. A stalled
// receiver freezes the sequencer at its next emit, which holds req_ready low.
// Synchronous reset clears the window pointers, tick count and end flag and
// restores the CSR defaults; the ack and stamp RAMs are written per frame on
// its send. After the end marker, requests are accepted and ignored.
`timescale 1ns / 1ps
module selective_repeat_sender (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [srs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [srs_pkg::ACK_W-1:0]       req_ack_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [srs_pkg::FRAME_NUM_W-1:0] rsp_frame_number,
   output logic [srs_pkg::KIND_W-1:0]      rsp_kind,
   output logic                            rsp_last
);
   import srs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: walks slide, scan, send and flush steps per request
   srs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   // state, ack and stamp RAMs and response registers
   srs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_command      (req_command),
      .req_ack_number   (req_ack_number),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_number (rsp_frame_number),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/srs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module srs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srs_datapath.sv =====
// Datapath of the selective repeat sender: config registers, window pointers,
// ack RAM, stamp RAM, result hold and output registers. Uses srs_pkg, srs_ram.
`timescale 1ns / 1ps
`include "selective_repeat_sender_macros.svh"
module srs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [srs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_command,
   input  logic [srs_pkg::ACK_W-1:0]       req_ack_number,
   input  srs_pkg::ctrl_cmd_type           cmd,
   output srs_pkg::dp_status_type          status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [srs_pkg::FRAME_NUM_W-1:0] rsp_frame_number,
   output logic [srs_pkg::KIND_W-1:0]      rsp_kind,
   output logic                            rsp_last
);
   import srs_pkg::*;

   // config
   logic [TOTAL_W-1:0]   total_ff;
   logic [WINDOW_W-1:0]  window_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [COUNT_W-1:0]   eff_total;
   logic [WIN_W-1:0]     eff_win;
   logic [EXT_W-1:0]     win_ext;
   logic [TIMEOUT_W-1:0] eff_tmo;

   // protocol state
   logic [COUNT_W-1:0]     base_ff, base_in;
   logic [COUNT_W-1:0]     next_ff, next_in;
   logic [COUNT_W-1:0]     idx_ff, idx_in;
   logic [STAMP_W-1:0]     tick_ff, tick_in;
   logic                   finished_ff, finished_in;

   // result hold and output registers
   logic                   hold_valid_ff, hold_valid_in;
   logic [FRAME_NUM_W-1:0] hold_frame_ff, hold_frame_in;
   kind_type               hold_kind_ff, hold_kind_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_NUM_W-1:0] rsp_frame_ff, rsp_frame_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   new_valid;
   logic [FRAME_NUM_W-1:0] new_frame;
   kind_type               new_kind;

   logic                   out_free;
   logic                   ack_in_range;
   logic [STAMP_W-1:0]     stamp_rdata;
   logic [STAMP_W-1:0]     age;
   logic                   stamp_wr_en;
   logic [FRAME_W-1:0]     stamp_wr_addr;
   logic                   ack_rdata;
   logic                   ack_wr_en;
   logic                   ack_wr_data;
   logic [FRAME_W-1:0]     ack_wr_addr;
   logic                   ack_rd_en;
   logic [FRAME_W-1:0]     ack_rd_addr;
   logic [SUM_W-1:0]       win_end;
   logic [SUM_W-1:0]       outstanding;

   // effective config values
   always_comb begin
      if (total_ff == '0) begin
         eff_total = COUNT_W'(1);
      end else if (EXT_W'(total_ff) > EXT_W'(FRAME_LIMIT)) begin
         eff_total = COUNT_W'(FRAME_LIMIT);
      end else begin
         eff_total = COUNT_W'(total_ff);
      end

      if (window_ff == '0) begin
         win_ext = EXT_W'(1);
      end else begin
         win_ext = EXT_W'(window_ff);
      end
      if (win_ext > EXT_W'(WINDOW_LIMIT)) begin
         win_ext = EXT_W'(WINDOW_LIMIT);
      end
      if (win_ext > EXT_W'(eff_total)) begin
         win_ext = EXT_W'(eff_total);
      end
      eff_win = win_ext[WIN_W-1:0];

      eff_tmo = (timeout_ff == '0) ? TIMEOUT_W'(1) : timeout_ff;
   end

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign age          = tick_ff - stamp_rdata;
   assign win_end      = {1'b0, base_ff} + SUM_W'(eff_win);
   assign outstanding  = {1'b0, next_ff} - {1'b0, base_ff};
   assign ack_in_range = (COUNT_W'(req_ack_number) >= base_ff) &&
                         (COUNT_W'(req_ack_number) < next_ff);

   // ack RAM data is only trusted for outstanding frames
   always_comb begin
      status.slide_more = (base_ff < next_ff) && ack_rdata;
      status.scan_done  = (idx_ff >= next_ff);
      status.scan_acked = ack_rdata;
      status.timed_out  = (age >= STAMP_W'(eff_tmo));
      status.at_end     = (base_ff >= eff_total);
      status.send_more  = ({1'b0, next_ff} < win_end) && (next_ff < eff_total);
      status.emit_ok    = !hold_valid_ff || out_free;
   end

   // next state
   always_comb begin
      base_in       = base_ff;
      next_in       = next_ff;
      idx_in        = idx_ff;
      tick_in       = tick_ff;
      finished_in   = finished_ff;
      hold_valid_in = hold_valid_ff;
      hold_frame_in = hold_frame_ff;
      hold_kind_in  = hold_kind_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      new_valid     = 1'b0;
      new_frame     = '0;
      new_kind      = KIND_NEW;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         idx_in = base_ff;
         if (req_command == CMD_TICK) begin
            tick_in = tick_ff + STAMP_W'(1);
         end
      end
      if (cmd.slide_step) begin
         base_in = base_ff + COUNT_W'(1);
      end
      if (cmd.scan_adv) begin
         idx_in = idx_ff + COUNT_W'(1);
      end
      if (cmd.retx) begin
         new_valid = 1'b1;
         new_frame = FRAME_NUM_W'(idx_ff);
         new_kind  = KIND_RETX;
         idx_in    = idx_ff + COUNT_W'(1);
      end
      if (cmd.end_mark) begin
         new_valid   = 1'b1;
         new_frame   = '0;
         new_kind    = KIND_END;
         finished_in = 1'b1;
      end
      if (cmd.send_new) begin
         new_valid = 1'b1;
         new_frame = FRAME_NUM_W'(next_ff);
         new_kind  = KIND_NEW;
         next_in   = next_ff + COUNT_W'(1);
      end

      // one result is held back so the final one can be flagged
      if (new_valid) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_frame_in = hold_frame_ff;
            rsp_kind_in  = hold_kind_ff;
            rsp_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_frame_in = new_frame;
         hold_kind_in  = new_kind;
      end
      if (cmd.flush && hold_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_frame_in  = hold_frame_ff;
         rsp_kind_in   = hold_kind_ff;
         rsp_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= TOTAL_RESET;
         window_ff     <= WINDOW_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         base_ff       <= '0;
         next_ff       <= '0;
         idx_ff        <= '0;
         tick_ff       <= '0;
         finished_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TOTAL: begin
                  total_ff <= csr_wdata[TOTAL_W-1:0];
               end
               CSR_WINDOW: begin
                  window_ff <= csr_wdata[WINDOW_W-1:0];
               end
               CSR_TIMEOUT: begin
                  timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         base_ff       <= base_in;
         next_ff       <= next_in;
         idx_ff        <= idx_in;
         tick_ff       <= tick_in;
         finished_ff   <= finished_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_frame_ff <= hold_frame_in;
      hold_kind_ff  <= hold_kind_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ack store: cleared when a frame is sent, set by an in-range ack
   assign ack_wr_en   = (cmd.accept && (req_command == CMD_ACK) && ack_in_range) ||
                        cmd.send_new;
   assign ack_wr_addr = cmd.send_new ? next_ff[FRAME_W-1:0] : FRAME_W'(req_ack_number);
   assign ack_wr_data = !cmd.send_new;
   assign ack_rd_en   = cmd.slide_read || cmd.scan_read;
   assign ack_rd_addr = cmd.slide_read ? base_ff[FRAME_W-1:0] : idx_ff[FRAME_W-1:0];

   srs_ram #(
      .WIDTH (1),
      .DEPTH (FRAME_LIMIT)
   ) u_ack_ram (
      .clock   (clock),
      .wr_en   (ack_wr_en),
      .wr_addr (ack_wr_addr),
      .wr_data (ack_wr_data),
      .rd_en   (ack_rd_en),
      .rd_addr (ack_rd_addr),
      .rd_data (ack_rdata)
   );

   // stamp store: written on every send and resend
   assign stamp_wr_en   = cmd.retx || cmd.send_new;
   assign stamp_wr_addr = cmd.retx ? idx_ff[FRAME_W-1:0] : next_ff[FRAME_W-1:0];

   srs_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (FRAME_LIMIT)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (stamp_wr_addr),
      .wr_data (tick_ff),
      .rd_en   (cmd.scan_read),
      .rd_addr (idx_ff[FRAME_W-1:0]),
      .rd_data (stamp_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_last         = rsp_last_ff;

   `SRS_ASSERT_NEVER(a_base_le_next, clock, reset, base_ff > next_ff, "window base passed next frame")
   `SRS_ASSERT_NEVER(a_window_fits, clock, reset, outstanding > SUM_W'(WINDOW_LIMIT), "too many outstanding frames")
   `SRS_ASSERT_NEVER(a_next_limit, clock, reset, next_ff > COUNT_W'(FRAME_LIMIT), "next frame beyond frame limit")
   `SRS_ASSERT(a_emit_slot, clock, reset, (cmd.retx || cmd.end_mark || cmd.send_new) && hold_valid_ff |-> out_free, "result emitted while output register busy")
   `SRS_ASSERT(a_quiet_after_end, clock, reset, finished_ff |-> !(cmd.retx || cmd.send_new || cmd.accept), "activity after end of transfer")

endmodule

// ===== rtl/srs_ctrl.sv =====
// Controller state machine of the selective repeat sender.
// Uses srs_pkg; drives the datapath commands from its status.
`timescale 1ns / 1ps
module srs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  srs_pkg::dp_status_type status,
   output srs_pkg::ctrl_cmd_type  cmd
);
   import srs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_command == CMD_ACK) ? ST_SLIDE : ST_SCAN;
            end
         end
         ST_SLIDE: begin
            // ack RAM read at the base, tested next cycle
            cmd.slide_read = 1'b1;
            state_in       = ST_SLIDE_CHK;
         end
         ST_SLIDE_CHK: begin
            if (status.slide_more) begin
               cmd.slide_step = 1'b1;
               state_in       = ST_SLIDE;
            end else begin
               state_in = ST_END_CHK;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_END_CHK;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.scan_acked || !status.timed_out) begin
               cmd.scan_adv = 1'b1;
               state_in     = ST_SCAN;
            end else if (status.emit_ok) begin
               cmd.retx = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_END_CHK: begin
            if (!status.at_end) begin
               state_in = ST_SEND;
            end else if (status.emit_ok) begin
               cmd.end_mark = 1'b1;
               state_in     = ST_FLUSH_END;
            end
         end
         ST_SEND: begin
            if (!status.send_more) begin
               state_in = ST_FLUSH;
            end else if (status.emit_ok) begin
               cmd.send_new = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.emit_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_FLUSH_END: begin
            if (status.emit_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_FINISHED;
            end
         end
         ST_FINISHED: begin
            // transfers are taken and dropped
            req_ready = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
